/* hw/rtl/cfrf_pkg.sv */
// Package for the CAN frame ring FIFO: sizes, status codes, the command word
// passed from the front end to the back end, and pointer helper functions.
// No dependencies.
package cfrf_pkg;

  localparam int RING_DEPTH  = 64;
  localparam int MAX_PAYLOAD = 64;

  localparam int PTR_W   = $clog2(2 * RING_DEPTH);
  localparam int SLOT_W  = $clog2(RING_DEPTH);
  localparam int POS_W   = $clog2(MAX_PAYLOAD + 1);
  localparam int BADDR_W = $clog2(RING_DEPTH * MAX_PAYLOAD);
  localparam int QDEPTH  = 2;
  localparam int QIDX_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [1:0] ST_WR_OK    = 2'd0;
  localparam logic [1:0] ST_WR_DROP  = 2'd1;
  localparam logic [1:0] ST_RD_DATA  = 2'd2;
  localparam logic [1:0] ST_RD_EMPTY = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic        op;
    logic        first;
    logic        ended;
    logic [31:0] id;
    logic [15:0] flen;
    logic [7:0]  dbyte;
    logic [15:0] rlim;
  } cmd_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
    if (p >= PTR_W'(RING_DEPTH)) begin
      return SLOT_W'(p - PTR_W'(RING_DEPTH));
    end
    return SLOT_W'(p);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(2 * RING_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] fill_of(input logic [PTR_W-1:0] wp,
                                               input logic [PTR_W-1:0] rp);
    logic [PTR_W:0] t;
    t = {1'b0, wp} + (PTR_W + 1)'(2 * RING_DEPTH) - {1'b0, rp};
    if (wp >= rp) begin
      return wp - rp;
    end
    return PTR_W'(t);
  endfunction

  function automatic logic [BADDR_W-1:0] baddr(input logic [SLOT_W-1:0] s,
                                               input logic [POS_W-1:0] pos);
    return BADDR_W'(s) * BADDR_W'(MAX_PAYLOAD) + BADDR_W'(pos);
  endfunction

endpackage

/* hw/rtl/cfrf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module cfrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/cfrf_front.sv */
// Front end: accepts words, tracks frame boundaries and builds commands.
// Depends on cfrf_pkg.
module cfrf_front import cfrf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        q_full,
  input  logic        in_op,
  input  logic [31:0] in_frame_id,
  input  logic [15:0] in_frame_len,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_part,
  input  logic [15:0] in_read_limit,
  output logic        busy,
  output logic        push,
  output cmd_t        cmd
);

  logic in_prog_r, in_prog_nxt;
  logic first;
  logic ended;

  assign busy  = q_full;
  assign push  = start && !q_full;
  assign first = !in_prog_r;
  assign ended = in_last_part || (first && (in_frame_len == 16'd0));

  always_comb begin
    cmd.op    = in_op;
    cmd.first = first;
    cmd.ended = ended;
    cmd.id    = in_frame_id;
    cmd.flen  = in_frame_len;
    cmd.dbyte = in_data_byte;
    cmd.rlim  = in_read_limit;
    in_prog_nxt = in_prog_r;
    if (push && (in_op == OP_WRITE)) begin
      in_prog_nxt = !ended;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_prog_r <= 1'b0;
    end else begin
      in_prog_r <= in_prog_nxt;
    end
  end

endmodule

/* hw/rtl/cfrf_queue.sv */
// Short command queue between the front end and the back end.
// Depends on cfrf_pkg.
module cfrf_queue import cfrf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic valid,
  output logic full,
  output cmd_t head
);

  cmd_t              entry_r [QDEPTH];
  logic [QIDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [QIDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign valid = (cnt_r != '0);
  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign head  = entry_r[rd_idx_r];

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_idx_nxt = (wr_idx_r == QIDX_W'(QDEPTH - 1)) ? '0 : wr_idx_r + QIDX_W'(1);
    end
    if (pop) begin
      rd_idx_nxt = (rd_idx_r == QIDX_W'(QDEPTH - 1)) ? '0 : rd_idx_r + QIDX_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_idx_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/cfrf_back.sv */
// Back end: executes queued commands against the ring memories and drives
// the result registers. Depends on cfrf_pkg.
module cfrf_back import cfrf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               id_we,
  output logic [SLOT_W-1:0]  id_waddr,
  output logic [31:0]        id_wdata,
  output logic [SLOT_W-1:0]  hdr_raddr,
  input  logic [31:0]        id_rdata,
  output logic               len_we,
  output logic [POS_W-1:0]   len_wdata,
  input  logic [POS_W-1:0]   len_rdata,
  output logic               byte_we,
  output logic [BADDR_W-1:0] byte_waddr,
  output logic [7:0]         byte_wdata,
  output logic [BADDR_W-1:0] byte_raddr,
  input  logic [7:0]         byte_rdata,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic [31:0]        out_id,
  output logic [6:0]         out_len,
  output logic [7:0]         out_byte,
  output logic               out_byte_valid,
  output logic               out_last_result,
  output logic [31:0]        out_drop_total,
  output logic [6:0]         out_fill_level
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_HDR   = 2'd1;
  localparam logic [1:0] S_BYTES = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [31:0]       drop_r, drop_nxt;
  logic              wr_rej_r, wr_rej_nxt;
  logic [POS_W-1:0]  wr_pos_r, wr_pos_nxt;
  logic [POS_W-1:0]  wr_dlen_r, wr_dlen_nxt;
  logic [31:0]       wr_id_r, wr_id_nxt;
  logic [15:0]       rlim_r, rlim_nxt;
  logic [POS_W-1:0]  rd_len_r, rd_len_nxt;
  logic [POS_W-1:0]  rd_cnt_r, rd_cnt_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [31:0]       rd_id_r, rd_id_nxt;

  logic              strobe_r, strobe_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [31:0]       oid_r, oid_nxt;
  logic [6:0]        olen_r, olen_nxt;
  logic [7:0]        obyte_r, obyte_nxt;
  logic              obv_r, obv_nxt;
  logic              olast_r, olast_nxt;
  logic [31:0]       odrop_r, odrop_nxt;
  logic [6:0]        ofill_r, ofill_nxt;

  logic [PTR_W-1:0]  fill_cur;
  logic [SLOT_W-1:0] ws;
  logic              w_rej;
  logic [POS_W-1:0]  w_dlen;
  logic [31:0]       w_id;
  logic [POS_W-1:0]  w_pos;
  logic              w_store;
  logic [POS_W-1:0]  hdr_len;
  logic [POS_W-1:0]  cnt_inc;
  logic              rd_last;

  assign fill_cur = fill_of(wp_r, rp_r);
  assign ws       = slot_of(wp_r);
  assign w_rej    = q_cmd.first ? ((q_cmd.flen > 16'(MAX_PAYLOAD)) ||
                                   (fill_cur >= PTR_W'(RING_DEPTH))) : wr_rej_r;
  assign w_dlen   = q_cmd.first ? POS_W'(q_cmd.flen) : wr_dlen_r;
  assign w_id     = q_cmd.first ? q_cmd.id : wr_id_r;
  assign w_pos    = q_cmd.first ? '0 : wr_pos_r;
  assign w_store  = !w_rej && (w_pos < w_dlen);
  assign hdr_len  = (16'(len_rdata) > rlim_r) ? POS_W'(rlim_r) : len_rdata;
  assign cnt_inc  = rd_cnt_r + POS_W'(1);
  assign rd_last  = (cnt_inc == rd_len_r);

  assign hdr_raddr  = slot_of(rp_r);
  assign byte_raddr = baddr(rd_slot_r, (state_r == S_HDR) ? '0 : cnt_inc);
  assign byte_waddr = baddr(ws, w_pos);
  assign byte_wdata = q_cmd.dbyte;
  assign id_waddr   = ws;
  assign id_wdata   = w_id;

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    drop_nxt    = drop_r;
    wr_rej_nxt  = wr_rej_r;
    wr_pos_nxt  = wr_pos_r;
    wr_dlen_nxt = wr_dlen_r;
    wr_id_nxt   = wr_id_r;
    rlim_nxt    = rlim_r;
    rd_len_nxt  = rd_len_r;
    rd_cnt_nxt  = rd_cnt_r;
    rd_slot_nxt = rd_slot_r;
    rd_id_nxt   = rd_id_r;
    q_pop       = 1'b0;
    id_we       = 1'b0;
    len_we      = 1'b0;
    len_wdata   = w_pos;
    byte_we     = 1'b0;
    strobe_nxt  = 1'b0;
    status_nxt  = status_r;
    oid_nxt     = oid_r;
    olen_nxt    = olen_r;
    obyte_nxt   = obyte_r;
    obv_nxt     = obv_r;
    olast_nxt   = olast_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.op == OP_WRITE) begin
            wr_rej_nxt  = w_rej;
            wr_dlen_nxt = w_dlen;
            wr_id_nxt   = w_id;
            wr_pos_nxt  = w_pos;
            if (w_store) begin
              byte_we    = 1'b1;
              wr_pos_nxt = w_pos + POS_W'(1);
            end
            if (q_cmd.ended) begin
              strobe_nxt = 1'b1;
              oid_nxt    = '0;
              olen_nxt   = '0;
              obyte_nxt  = '0;
              obv_nxt    = 1'b0;
              olast_nxt  = 1'b1;
              if (w_rej) begin
                drop_nxt   = drop_r + 32'd1;
                status_nxt = ST_WR_DROP;
              end else begin
                id_we      = 1'b1;
                len_we     = 1'b1;
                len_wdata  = wr_pos_nxt;
                wp_nxt     = ptr_inc(wp_r);
                status_nxt = ST_WR_OK;
              end
              wr_rej_nxt = 1'b0;
              wr_pos_nxt = '0;
            end
          end else if (fill_cur == '0) begin
            strobe_nxt = 1'b1;
            status_nxt = ST_RD_EMPTY;
            oid_nxt    = '0;
            olen_nxt   = '0;
            obyte_nxt  = '0;
            obv_nxt    = 1'b0;
            olast_nxt  = 1'b1;
          end else begin
            rlim_nxt    = q_cmd.rlim;
            rd_slot_nxt = slot_of(rp_r);
            rp_nxt      = ptr_inc(rp_r);
            state_nxt   = S_HDR;
          end
        end
      end
      S_HDR: begin
        rd_id_nxt  = id_rdata;
        rd_len_nxt = hdr_len;
        rd_cnt_nxt = '0;
        if (hdr_len == '0) begin
          strobe_nxt = 1'b1;
          status_nxt = ST_RD_DATA;
          oid_nxt    = id_rdata;
          olen_nxt   = '0;
          obyte_nxt  = '0;
          obv_nxt    = 1'b0;
          olast_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_BYTES;
        end
      end
      S_BYTES: begin
        strobe_nxt = 1'b1;
        status_nxt = ST_RD_DATA;
        oid_nxt    = rd_id_r;
        olen_nxt   = 7'(rd_len_r);
        obyte_nxt  = byte_rdata;
        obv_nxt    = 1'b1;
        olast_nxt  = rd_last;
        if (rd_last) begin
          state_nxt = S_IDLE;
        end else begin
          rd_cnt_nxt = cnt_inc;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    odrop_nxt = strobe_nxt ? drop_nxt : odrop_r;
    ofill_nxt = strobe_nxt ? 7'(fill_of(wp_nxt, rp_nxt)) : ofill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wp_r     <= '0;
      rp_r     <= '0;
      drop_r   <= '0;
      wr_rej_r <= 1'b0;
      wr_pos_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      drop_r   <= drop_nxt;
      wr_rej_r <= wr_rej_nxt;
      wr_pos_r <= wr_pos_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_dlen_r <= wr_dlen_nxt;
    wr_id_r   <= wr_id_nxt;
    rlim_r    <= rlim_nxt;
    rd_len_r  <= rd_len_nxt;
    rd_cnt_r  <= rd_cnt_nxt;
    rd_slot_r <= rd_slot_nxt;
    rd_id_r   <= rd_id_nxt;
    status_r  <= status_nxt;
    oid_r     <= oid_nxt;
    olen_r    <= olen_nxt;
    obyte_r   <= obyte_nxt;
    obv_r     <= obv_nxt;
    olast_r   <= olast_nxt;
    odrop_r   <= odrop_nxt;
    ofill_r   <= ofill_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_id          = oid_r;
  assign out_len         = olen_r;
  assign out_byte        = obyte_r;
  assign out_byte_valid  = obv_r;
  assign out_last_result = olast_r;
  assign out_drop_total  = odrop_r;
  assign out_fill_level  = ofill_r;

endmodule

/* hw/rtl/can_frame_ring_fifo.sv */
// A write word that ends a frame, or a read of an empty ring, gives its result through
// the command queue and then the back end's result registers; a read of L bytes first reads
// the slot header, then gives the bytes on consecutive cycles, or one result if L is zero.
// One write word per cycle while busy is low; a read holds the back end until its last byte,
// during which up to two further words queue before busy rises. Reset (rst_n low,
// synchronous) empties the ring and clears the drop count; the receiver cannot stall.
module can_frame_ring_fifo import cfrf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [31:0] in_frame_id,
  input  logic [15:0] in_frame_len,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_part,
  input  logic [15:0] in_read_limit,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [31:0] out_id,
  output logic [6:0]  out_len,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_last_result,
  output logic [31:0] out_drop_total,
  output logic [6:0]  out_fill_level
);

  // The front end only tracks where frames begin and end, which depends on
  // the incoming words alone; every decision that needs the ring's state
  // (dropping, emptiness) is taken by the back end in word order.
  logic               q_full;
  logic               q_push;
  cmd_t               q_in;
  logic               q_valid;
  logic               q_pop;
  cmd_t               q_head;

  logic               id_we;
  logic [SLOT_W-1:0]  id_waddr;
  logic [31:0]        id_wdata;
  logic [SLOT_W-1:0]  hdr_raddr;
  logic [31:0]        id_rdata;
  logic               len_we;
  logic [POS_W-1:0]   len_wdata;
  logic [POS_W-1:0]   len_rdata;
  logic               byte_we;
  logic [BADDR_W-1:0] byte_waddr;
  logic [7:0]         byte_wdata;
  logic [BADDR_W-1:0] byte_raddr;
  logic [7:0]         byte_rdata;

  cfrf_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .q_full(q_full),
    .in_op(in_op), .in_frame_id(in_frame_id), .in_frame_len(in_frame_len),
    .in_data_byte(in_data_byte), .in_last_part(in_last_part),
    .in_read_limit(in_read_limit), .busy(busy), .push(q_push), .cmd(q_in)
  );

  cfrf_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_cmd(q_in), .pop(q_pop),
    .valid(q_valid), .full(q_full), .head(q_head)
  );

  // Slot headers and payload bytes live in three RAMs; the id and length
  // of a slot are written together when its frame completes.
  cfrf_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_id_ram (
    .clk(clk), .we(id_we), .waddr(id_waddr), .wdata(id_wdata),
    .raddr(hdr_raddr), .rdata(id_rdata)
  );

  cfrf_ram #(.WIDTH(POS_W), .DEPTH(RING_DEPTH)) u_len_ram (
    .clk(clk), .we(len_we), .waddr(id_waddr), .wdata(len_wdata),
    .raddr(hdr_raddr), .rdata(len_rdata)
  );

  cfrf_ram #(.WIDTH(8), .DEPTH(RING_DEPTH * MAX_PAYLOAD)) u_byte_ram (
    .clk(clk), .we(byte_we), .waddr(byte_waddr), .wdata(byte_wdata),
    .raddr(byte_raddr), .rdata(byte_rdata)
  );

  cfrf_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_head), .q_pop(q_pop),
    .id_we(id_we), .id_waddr(id_waddr), .id_wdata(id_wdata),
    .hdr_raddr(hdr_raddr), .id_rdata(id_rdata),
    .len_we(len_we), .len_wdata(len_wdata), .len_rdata(len_rdata),
    .byte_we(byte_we), .byte_waddr(byte_waddr), .byte_wdata(byte_wdata),
    .byte_raddr(byte_raddr), .byte_rdata(byte_rdata),
    .out_strobe(out_strobe), .out_status(out_status), .out_id(out_id),
    .out_len(out_len), .out_byte(out_byte), .out_byte_valid(out_byte_valid),
    .out_last_result(out_last_result), .out_drop_total(out_drop_total),
    .out_fill_level(out_fill_level)
  );

`ifndef SYNTHESIS
  // A word that carries a payload byte always belongs to a non-empty read.
  a_byte_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_byte_valid) |-> (out_len != 7'd0 && out_status == ST_RD_DATA))
    else $error("payload byte delivered with zero length or wrong status");

  // Every result without a byte is the only result of its word.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_byte_valid) |-> out_last_result)
    else $error("byte-less result not marked last");

  // The drop count moves only together with a drop report.
  a_drop_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(out_strobe) && out_drop_total != $past(out_drop_total))
      |-> (out_status == ST_WR_DROP))
    else $error("drop count changed without a drop");
`endif

endmodule

/* dv/can_frame_ring_fifo_tb.sv */
// Self-checking testbench for the CAN frame ring FIFO. It predicts every result word
// with its own model of the ring and checks the block's output against that model.
// Depends on cfrf_pkg and can_frame_ring_fifo.
module can_frame_ring_fifo_tb;
  import cfrf_pkg::*;

  // Scoreboard: keeps a private copy of the ring, works out the results each accepted
  // word should cause, and compares every strobed result with the oldest one due.
  class frame_ring_scoreboard;
    typedef struct {
      logic [1:0]  status;
      logic [31:0] id;
      logic [6:0]  len;
      logic [7:0]  data;
      logic        valid;
      logic        last;
      logic [31:0] drops;
      logic [6:0]  fill;
    } ring_result_t;

    logic [31:0] slot_id [RING_DEPTH];
    int unsigned slot_len [RING_DEPTH];
    logic [7:0]  slot_data [RING_DEPTH * MAX_PAYLOAD];
    int unsigned rd_ptr, wr_ptr, wr_pos;
    logic [31:0] drop_count;
    bit          writing, rejected;
    ring_result_t due_results[$];
    int          errors;

    function int unsigned frames_held();
      return (wr_ptr + 2 * RING_DEPTH - rd_ptr) % (2 * RING_DEPTH);
    endfunction

    function void push_result(logic [1:0] st, logic [31:0] id, int unsigned len,
                              logic [7:0] data, logic valid, logic last);
      ring_result_t r;
      r.status = st;
      r.id     = id;
      r.len    = 7'(len);
      r.data   = data;
      r.valid  = valid;
      r.last   = last;
      r.drops  = drop_count;
      r.fill   = 7'(frames_held());
      due_results.push_back(r);
    endfunction

    // Notes one accepted word and queues the results it is expected to cause.
    function void note_word(logic op, logic [31:0] id, logic [15:0] flen,
                            logic [7:0] data, logic last_part, logic [15:0] rlim);
      int unsigned slot, n;
      bit ends;
      if (op == OP_WRITE) begin
        slot = wr_ptr % RING_DEPTH;
        ends = last_part;
        if (!writing) begin
          writing  = 1;
          wr_pos   = 0;
          rejected = (flen > MAX_PAYLOAD) || (frames_held() >= RING_DEPTH);
          if (!rejected) begin
            slot_id[slot]  = id;
            slot_len[slot] = flen;
          end
          if (flen == 0) ends = 1;
        end
        // Bytes past the declared length, and those of a dropped frame, are lost.
        if (!rejected && wr_pos < slot_len[slot] && wr_pos < MAX_PAYLOAD) begin
          slot_data[slot * MAX_PAYLOAD + wr_pos] = data;
          wr_pos++;
        end
        if (!ends) return;
        if (rejected) begin
          drop_count++;
          push_result(ST_WR_DROP, '0, 0, '0, 1'b0, 1'b1);
        end else begin
          slot_len[slot] = wr_pos;
          wr_ptr = (wr_ptr + 1) % (2 * RING_DEPTH);
          push_result(ST_WR_OK, '0, 0, '0, 1'b0, 1'b1);
        end
        writing  = 0;
        rejected = 0;
        wr_pos   = 0;
        return;
      end
      if (frames_held() == 0) begin
        push_result(ST_RD_EMPTY, '0, 0, '0, 1'b0, 1'b1);
        return;
      end
      slot = rd_ptr % RING_DEPTH;
      n = slot_len[slot];
      if (rlim < n) n = rlim;
      rd_ptr = (rd_ptr + 1) % (2 * RING_DEPTH);
      if (n == 0) begin
        push_result(ST_RD_DATA, slot_id[slot], 0, '0, 1'b0, 1'b1);
        return;
      end
      for (int k = 0; k < n; k++)
        push_result(ST_RD_DATA, slot_id[slot], n, slot_data[slot * MAX_PAYLOAD + k],
                    1'b1, k == n - 1);
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result with none due: status %0d id %h len %0d byte %h",
                   got.status, got.id, got.len, got.data);
        return;
      end
      want = due_results.pop_front();
      if (got != want) begin
        errors++;
        if (errors <= 10)
          $display({"ERROR: expected st %0d id %h len %0d byte %h v %b last %b drops %0d ",
                    "fill %0d, got st %0d id %h len %0d byte %h v %b last %b drops %0d ",
                    "fill %0d"},
                   want.status, want.id, want.len, want.data, want.valid, want.last,
                   want.drops, want.fill, got.status, got.id, got.len, got.data,
                   got.valid, got.last, got.drops, got.fill);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_op = OP_WRITE;
  logic [31:0] in_frame_id = '0;
  logic [15:0] in_frame_len = '0;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_part = 1'b0;
  logic [15:0] in_read_limit = '0;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic [31:0] out_id;
  logic [6:0]  out_len;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_last_result;
  logic [31:0] out_drop_total;
  logic [6:0]  out_fill_level;

  frame_ring_scoreboard sb = new();
  bit gaps_on = 1'b1;
  int words_sent = 0;

  always #5 clk = ~clk;

  can_frame_ring_fifo dut (.*);

  // Results cannot be held off, so every strobe is taken at the edge ending its cycle.
  always @(posedge clk) begin
    frame_ring_scoreboard::ring_result_t r;
    if (rst_n && out_strobe) begin
      r.status = out_status;
      r.id     = out_id;
      r.len    = out_len;
      r.data   = out_byte;
      r.valid  = out_byte_valid;
      r.last   = out_last_result;
      r.drops  = out_drop_total;
      r.fill   = out_fill_level;
      sb.check_result(r);
    end
  end

  // Presents one word, optionally after an idle burst, and waits until it is taken.
  // The call returns on the accepting edge with start still high.
  task automatic send_word(logic op, logic [31:0] id, logic [15:0] flen,
                           logic [7:0] data, logic last_part, logic [15:0] rlim);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start         <= 1'b1;
    in_op         <= op;
    in_frame_id   <= id;
    in_frame_len  <= flen;
    in_data_byte  <= data;
    in_last_part  <= last_part;
    in_read_limit <= rlim;
    do @(posedge clk); while (busy);
    sb.note_word(op, id, flen, data, last_part, rlim);
    words_sent++;
  endtask

  task automatic read_frame(logic [15:0] rlim);
    send_word(OP_READ, $urandom, 16'($urandom), 8'($urandom), 1'($urandom), rlim);
  endtask

  // Streams a frame of declared length flen as nwords write words; a zero length
  // frame takes its single word whatever last_part holds. Reads may slip in between.
  task automatic write_frame(logic [31:0] id, logic [15:0] flen, int nwords,
                             int read_pct);
    if (flen == 0) begin
      send_word(OP_WRITE, id, flen, 8'($urandom), 1'($urandom), 16'($urandom));
      return;
    end
    for (int i = 0; i < nwords; i++) begin
      // Only the byte and the end flag matter after the first word, so vary the rest.
      send_word(OP_WRITE, (i == 0) ? id : $urandom, (i == 0) ? flen : 16'($urandom),
                8'($urandom), i == nwords - 1, 16'($urandom));
      if (i < nwords - 1 && $urandom_range(0, 99) < read_pct / 8)
        read_frame(16'($urandom_range(0, 70)));
    end
  endtask

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom_range(0, 3));
    if (r < 80) return 16'($urandom_range(4, 16));
    if (r < 92) return 16'($urandom_range(17, MAX_PAYLOAD));
    return 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
  endfunction

  function automatic logic [15:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 50) return 16'($urandom_range(1, 8));
    if (r < 80) return 16'($urandom_range(9, MAX_PAYLOAD));
    return 16'($urandom);
  endfunction

  initial begin
    int read_pct, n;
    logic [15:0] flen;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty read, zero length frames either way, extreme ids, bytes
    // and lengths, over-long and short streams, too-long frames, a read in mid-frame.
    read_frame(16'hFFFF);
    send_word(OP_WRITE, 32'hFFFF_FFFF, 16'd0, 8'hFF, 1'b0, 16'hFFFF);
    send_word(OP_WRITE, 32'h0000_0000, 16'd0, 8'h00, 1'b1, 16'h0000);
    send_word(OP_WRITE, 32'hA5A5_5A5A, 16'd2, 8'hFF, 1'b0, 16'd0);
    send_word(OP_WRITE, 32'h0, 16'hFFFF, 8'h00, 1'b1, 16'hFFFF);
    write_frame(32'h1234_5678, 16'd3, 6, 0);
    write_frame(32'h8765_4321, 16'd10, 4, 0);
    write_frame(32'hDEAD_BEEF, 16'hFFFF, 2, 0);
    write_frame(32'h0BAD_F00D, 16'(MAX_PAYLOAD + 1), 1, 0);
    send_word(OP_WRITE, 32'h5555_AAAA, 16'd4, 8'h55, 1'b0, 16'd0);
    read_frame(16'd0);
    read_frame(16'd1);
    send_word(OP_WRITE, 32'h0, 16'h0, 8'hAA, 1'b1, 16'hFFFF);
    read_frame(16'hFFFF);
    read_frame(16'd64);
    read_frame(16'd2);
    read_frame(16'd5);

    // Random part in three phases: balanced, write heavy so the ring fills and frames
    // are dropped for lack of room, then read heavy with no idling at the end.
    while (words_sent < 520) begin
      read_pct = (words_sent < 170) ? 45 : (words_sent < 330) ? 4 : 60;
      if (words_sent >= 440) gaps_on = 1'b0;
      if ($urandom_range(0, 99) < read_pct) begin
        read_frame(pick_limit());
      end else begin
        flen = (read_pct < 10 && $urandom_range(0, 1)) ? 16'd0 : pick_len();
        if (flen > MAX_PAYLOAD) n = $urandom_range(1, 8);
        else if ($urandom_range(0, 9) == 0) n = $urandom_range(1, flen);
        else if ($urandom_range(0, 9) == 0) n = flen + $urandom_range(1, 4);
        else n = flen;
        write_frame($urandom, flen, n, read_pct);
      end
    end
    // Close any frame still open so every word has its outcome reported.
    if (sb.writing) send_word(OP_WRITE, $urandom, 16'($urandom), 8'($urandom), 1'b1, '0);
    start <= 1'b0;

    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("can_frame_ring_fifo regression: pass");
    end else begin
      $display("can_frame_ring_fifo regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("can_frame_ring_fifo regression: fail");
    $finish;
  end

endmodule
